// ===== hdl/chosc_pkg.sv =====
// ----------------------------------------------------------------------------
// chosc_pkg: shared types and constants of the Chaikin oscillator
// Field widths, fixed-point formats, sequencer states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package chosc_pkg;

    localparam int PRICE_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int GAIN_BITS     = 16;

    localparam int FIELD_W = 32;
    localparam int VOL_W   = 32;
    localparam int LINE_W  = 48;
    localparam int AVG_W   = 64;
    localparam int OSC_W   = 49;
    localparam int COUNT_W = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int NUM_W    = PRICE_BITS + 3;
    localparam int DV_W     = PRICE_BITS + 2;
    localparam int Q_W      = FRACTION_BITS + 1;
    localparam int MUL_A_W  = (Q_W > GAIN_BITS) ? Q_W : GAIN_BITS;
    localparam int MUL_P_W  = MUL_A_W + VOL_W;
    localparam int FLOW_W   = VOL_W + 1;
    localparam int SUM_W    = LINE_W + 1;
    localparam int HALF_W   = AVG_W / 2;
    localparam int GPROD_W  = GAIN_BITS + HALF_W;
    localparam int DIFF_W   = AVG_W + 1;
    localparam int OMAG_W   = DIFF_W - GAIN_BITS;
    localparam int DIVCNT_W = $clog2(FRACTION_BITS);

    localparam logic [DIVCNT_W-1:0] DIVCNT_LAST = DIVCNT_W'(FRACTION_BITS - 1);
    localparam logic [Q_W-1:0]      Q_ONE       = Q_W'(1) << FRACTION_BITS;

    localparam logic signed [SUM_W-1:0] LINE_MAX_S = SUM_W'({(LINE_W-1){1'b1}});
    localparam logic signed [SUM_W-1:0] LINE_MIN_S = -LINE_MAX_S - SUM_W'(1);

    localparam logic [OMAG_W-1:0] OSC_POS_LIM = OMAG_W'({(OSC_W-1){1'b1}});
    localparam logic [OMAG_W-1:0] OSC_NEG_LIM = OMAG_W'({1'b1, {(OSC_W-1){1'b0}}});
    localparam logic [OSC_W-1:0]  OSC_MAX_V   = {1'b0, {(OSC_W-1){1'b1}}};
    localparam logic [OSC_W-1:0]  OSC_MIN_V   = {1'b1, {(OSC_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_FLOW_MUL,
        S_LINE,
        S_EMA_DIFF,
        S_EMA_MH,
        S_EMA_ML,
        S_EMA_STEP,
        S_EMA_UPD,
        S_OSC_DIFF,
        S_OSC_MAG,
        S_OUT
    } chosc_state_t;

    typedef enum logic [1:0] {
        MUL_FLOW,
        MUL_HI,
        MUL_LO
    } chosc_mul_sel_t;

    typedef enum logic [1:0] {
        CFG_FAST_GAIN,
        CFG_SLOW_GAIN,
        CFG_WARMUP_COUNT
    } chosc_cfg_idx_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] fast_gain;
        logic [GAIN_BITS-1:0] slow_gain;
        logic [COUNT_W-1:0]   warmup_count;
    } chosc_cfg_t;

    typedef struct packed {
        logic           load;
        logic           prep;
        logic           div_step;
        chosc_mul_sel_t mul_sel;
        logic           line_upd;
        logic           ema_diff;
        logic           hi_capture;
        logic           step_calc;
        logic           ema_upd;
        logic           avg_sel;
        logic           osc_diff;
        logic           osc_mag;
        logic           out_load;
    } chosc_cmd_t;

    typedef struct packed {
        logic first_bar;
        logic out_free;
    } chosc_sts_t;

endpackage

// ===== hdl/chosc_ifs.sv =====
// ----------------------------------------------------------------------------
// chosc_ifs: bar and result channels of the Chaikin oscillator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface chosc_bar_if
    import chosc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] close_price;
    logic [FIELD_W-1:0] high_price;
    logic [FIELD_W-1:0] low_price;
    logic [FIELD_W-1:0] bar_volume;
    logic               restart;

    modport source (
        output valid, close_price, high_price, low_price, bar_volume, restart,
        input  ready
    );
    modport sink (
        input  valid, close_price, high_price, low_price, bar_volume, restart,
        output ready
    );
endinterface

interface chosc_res_if
    import chosc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OSC_W-1:0] oscillator;
    logic                    valid_res;

    modport source (
        output valid, oscillator, valid_res,
        input  ready
    );
    modport sink (
        input  valid, oscillator, valid_res,
        output ready
    );
endinterface

// ===== hdl/chaikin_oscillator.sv =====
// ----------------------------------------------------------------------------
// chaikin_oscillator: Chaikin oscillator, one price bar per beat
// The first bar after reset or restart seeds the averages and skips their
// updates. A new bar is taken only after its predecessor's result is
// registered and the sequencer has returned to idle. The 16-step bit-serial
// divider and the two 16x32 gain products per average on the one shared
// multiplier dominate the sequence for a bar.
// Reset (rst_n, asynchronous, active low) clears the line, averages, bar count
// and output valid, and loads the default gains and warm-up count.
// ----------------------------------------------------------------------------
module chaikin_oscillator
    import chosc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    chosc_bar_if.sink          bar,
    chosc_res_if.source        result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    chosc_cfg_t cfg;
    chosc_cmd_t cmd;
    chosc_sts_t sts;

    chosc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    chosc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .bar_valid (bar.valid),
        .bar_ready (bar.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chosc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .sts         (sts),
        .close_price (bar.close_price),
        .high_price  (bar.high_price),
        .low_price   (bar.low_price),
        .bar_volume  (bar.bar_volume),
        .restart     (bar.restart),
        .res_valid   (result.valid),
        .res_ready   (result.ready),
        .oscillator  (result.oscillator),
        .valid_res   (result.valid_res)
    );

`ifndef SYNTHESIS
    // A bar is processed alone: the channel closes right after a beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        bar.valid && bar.ready |=> !bar.ready)
        else $error("bar channel stayed open after a beat");

    // The result register is only loaded when it is empty or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result.valid || result.ready))
        else $error("pending result overwritten");

    // Every new result beat comes from an output load of the sequencer.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.out_load))
        else $error("result valid without output load");
`endif

endmodule

// ===== hdl/chosc_cfg.sv =====
// ----------------------------------------------------------------------------
// chosc_cfg: configuration registers
// APB-style register file holding the two smoothing gains and the warm-up count.
// ----------------------------------------------------------------------------
module chosc_cfg
    import chosc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output chosc_cfg_t         cfg
);

    chosc_cfg_t     cfg_reg;
    chosc_cfg_t     cfg_next;
    chosc_cfg_idx_t reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = chosc_cfg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                CFG_FAST_GAIN:    cfg_next.fast_gain    = pwdata[GAIN_BITS-1:0];
                CFG_SLOW_GAIN:    cfg_next.slow_gain    = pwdata[GAIN_BITS-1:0];
                CFG_WARMUP_COUNT: cfg_next.warmup_count = pwdata[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            CFG_FAST_GAIN:    prdata = PDATA_W'(cfg_reg.fast_gain);
            CFG_SLOW_GAIN:    prdata = PDATA_W'(cfg_reg.slow_gain);
            CFG_WARMUP_COUNT: prdata = PDATA_W'(cfg_reg.warmup_count);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_gain    <= GAIN_BITS'(32768);
            cfg_reg.slow_gain    <= GAIN_BITS'(11916);
            cfg_reg.warmup_count <= COUNT_W'(10);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/chosc_ctrl.sv =====
// ----------------------------------------------------------------------------
// chosc_ctrl: bar sequencer
// Steps one bar through divide, flow multiply, line update, both average
// updates on the shared multiplier (not on a first bar) and the output stage.
// ----------------------------------------------------------------------------
module chosc_ctrl
    import chosc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       bar_valid,
    output logic       bar_ready,
    input  chosc_sts_t sts,
    output chosc_cmd_t cmd
);

    chosc_state_t        state_reg;
    chosc_state_t        state_next;
    logic [DIVCNT_W-1:0] div_cnt_reg;
    logic [DIVCNT_W-1:0] div_cnt_next;
    logic                avg_sel_reg;
    logic                avg_sel_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (bar_valid) state_next = S_PREP;
            S_PREP:     state_next = S_DIV;
            S_DIV:      if (div_cnt_reg == DIVCNT_LAST) state_next = S_FLOW_MUL;
            S_FLOW_MUL: state_next = S_LINE;
            S_LINE:     state_next = sts.first_bar ? S_OSC_DIFF : S_EMA_DIFF;
            S_EMA_DIFF: state_next = S_EMA_MH;
            S_EMA_MH:   state_next = S_EMA_ML;
            S_EMA_ML:   state_next = S_EMA_STEP;
            S_EMA_STEP: state_next = S_EMA_UPD;
            S_EMA_UPD:  state_next = avg_sel_reg ? S_OSC_DIFF : S_EMA_DIFF;
            S_OSC_DIFF: state_next = S_OSC_MAG;
            S_OSC_MAG:  state_next = S_OUT;
            S_OUT:      if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        avg_sel_next = avg_sel_reg;
        if (state_reg == S_PREP)
        begin
            div_cnt_next = '0;
        end
        if (state_reg == S_DIV)
        begin
            div_cnt_next = div_cnt_reg + DIVCNT_W'(1);
        end
        if (state_reg == S_LINE)
        begin
            avg_sel_next = 1'b0;
        end
        if (state_reg == S_EMA_UPD)
        begin
            avg_sel_next = !avg_sel_reg;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_FLOW;
        cmd.avg_sel = avg_sel_reg;
        bar_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                bar_ready = 1'b1;
                cmd.load  = bar_valid;
            end
            S_PREP:     cmd.prep = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_FLOW_MUL: cmd.mul_sel = MUL_FLOW;
            S_LINE:     cmd.line_upd = 1'b1;
            S_EMA_DIFF: cmd.ema_diff = 1'b1;
            S_EMA_MH:   cmd.mul_sel = MUL_HI;
            S_EMA_ML:
            begin
                cmd.mul_sel    = MUL_LO;
                cmd.hi_capture = 1'b1;
            end
            S_EMA_STEP: cmd.step_calc = 1'b1;
            S_EMA_UPD:  cmd.ema_upd = 1'b1;
            S_OSC_DIFF: cmd.osc_diff = 1'b1;
            S_OSC_MAG:  cmd.osc_mag = 1'b1;
            S_OUT:      cmd.out_load = sts.out_free;
            default:    cmd.mul_sel = MUL_FLOW;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            avg_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            avg_sel_reg <= avg_sel_next;
        end
    end

endmodule

// ===== hdl/chosc_dp.sv =====
// ----------------------------------------------------------------------------
// chosc_dp: oscillator datapath
// Bit-serial money-flow divider, shared gain and volume multiplier, saturating
// accumulation line, fast and slow averages, and the result register.
// ----------------------------------------------------------------------------
module chosc_dp
    import chosc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  chosc_cmd_t              cmd,
    input  chosc_cfg_t              cfg,
    output chosc_sts_t              sts,
    input  logic [FIELD_W-1:0]      close_price,
    input  logic [FIELD_W-1:0]      high_price,
    input  logic [FIELD_W-1:0]      low_price,
    input  logic [FIELD_W-1:0]      bar_volume,
    input  logic                    restart,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic signed [OSC_W-1:0] oscillator,
    output logic                    valid_res
);

    logic [PRICE_BITS-1:0]   c_reg;
    logic [PRICE_BITS-1:0]   h_reg;
    logic [PRICE_BITS-1:0]   l_reg;
    logic [VOL_W-1:0]        vol_reg;
    logic [DV_W-1:0]         d_reg;
    logic [DV_W-1:0]         rem_reg;
    logic [Q_W-1:0]          q_reg;
    logic                    neg_reg;
    logic                    div_act_reg;
    logic [MUL_P_W-1:0]      mul_reg;
    logic signed [LINE_W-1:0] line_reg;
    logic signed [AVG_W-1:0] fast_reg;
    logic signed [AVG_W-1:0] slow_reg;
    logic [COUNT_W-1:0]      bars_reg;
    logic                    up_reg;
    logic [AVG_W-1:0]        mag_reg;
    logic [GPROD_W-1:0]      hi_reg;
    logic [AVG_W-1:0]        step_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic                    oneg_reg;
    logic [OMAG_W-1:0]       omag_reg;
    logic signed [OSC_W-1:0] osc_reg;
    logic                    vres_reg;
    logic                    res_valid_reg;

    logic [NUM_W-1:0]        num_w;
    logic [DV_W-1:0]         den_w;
    logic [DV_W-1:0]         n_w;
    logic [DV_W-1:0]         d_w;
    logic                    zero_w;
    logic [DV_W-1:0]         rem2_w;
    logic                    ge_w;
    logic [MUL_A_W-1:0]      mul_a;
    logic [VOL_W-1:0]        mul_b;
    logic [GAIN_BITS-1:0]    gain_w;
    logic [FLOW_W-1:0]       flow_w;
    logic signed [SUM_W-1:0] sflow_w;
    logic signed [SUM_W-1:0] sum_w;
    logic signed [LINE_W-1:0] line_sat;
    logic signed [AVG_W-1:0] x_seed;
    logic signed [AVG_W-1:0] x_cur;
    logic signed [AVG_W-1:0] avg_cur;
    logic                    up_w;
    logic [DIFF_W-1:0]       dmag_w;
    logic [OSC_W-1:0]        osc_next;

    // Money-flow numerator 2*close - high - low and denominator high - low.
    assign num_w  = NUM_W'({c_reg, 1'b0}) - NUM_W'(h_reg) - NUM_W'(l_reg);
    assign den_w  = DV_W'(h_reg) - DV_W'(l_reg);
    assign n_w    = num_w[NUM_W-1] ? DV_W'(-num_w) : DV_W'(num_w);
    assign d_w    = den_w[DV_W-1] ? -den_w : den_w;
    assign zero_w = (num_w == '0) || (den_w == '0);

    assign rem2_w = {rem_reg[DV_W-2:0], 1'b0};
    assign ge_w   = rem2_w >= d_reg;

    assign gain_w = cmd.avg_sel ? cfg.slow_gain : cfg.fast_gain;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_FLOW:
            begin
                mul_a = MUL_A_W'(q_reg);
                mul_b = vol_reg;
            end
            MUL_HI:
            begin
                mul_a = MUL_A_W'(gain_w);
                mul_b = VOL_W'(mag_reg[AVG_W-1:HALF_W]);
            end
            MUL_LO:
            begin
                mul_a = MUL_A_W'(gain_w);
                mul_b = VOL_W'(mag_reg[HALF_W-1:0]);
            end
            default:
            begin
                mul_a = MUL_A_W'(q_reg);
                mul_b = vol_reg;
            end
        endcase
    end

    assign flow_w  = mul_reg[FRACTION_BITS +: FLOW_W];
    assign sflow_w = neg_reg ? -SUM_W'(flow_w) : SUM_W'(flow_w);
    assign sum_w   = SUM_W'(line_reg) + sflow_w;

    always_comb
    begin
        if (sum_w > LINE_MAX_S)
        begin
            line_sat = LINE_W'(LINE_MAX_S);
        end
        else if (sum_w < LINE_MIN_S)
        begin
            line_sat = LINE_W'(LINE_MIN_S);
        end
        else
        begin
            line_sat = LINE_W'(sum_w);
        end
    end

    assign x_seed  = {line_sat, {GAIN_BITS{1'b0}}};
    assign x_cur   = {line_reg, {GAIN_BITS{1'b0}}};
    assign avg_cur = cmd.avg_sel ? slow_reg : fast_reg;
    assign up_w    = x_cur >= avg_cur;

    assign dmag_w = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);

    always_comb
    begin
        if (oneg_reg)
        begin
            osc_next = (omag_reg > OSC_NEG_LIM) ? OSC_MIN_V : -OSC_W'(omag_reg);
        end
        else
        begin
            osc_next = (omag_reg > OSC_POS_LIM) ? OSC_MAX_V : OSC_W'(omag_reg);
        end
    end

    assign sts.first_bar = (bars_reg == '0);
    assign sts.out_free  = !res_valid_reg || res_ready;

    assign res_valid  = res_valid_reg;
    assign oscillator = osc_reg;
    assign valid_res  = vres_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= '0;
            fast_reg      <= '0;
            slow_reg      <= '0;
            bars_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && restart)
            begin
                line_reg <= '0;
                fast_reg <= '0;
                slow_reg <= '0;
                bars_reg <= '0;
            end
            if (cmd.line_upd)
            begin
                line_reg <= line_sat;
                if (bars_reg == '0)
                begin
                    fast_reg <= x_seed;
                    slow_reg <= x_seed;
                end
                if (bars_reg != '1)
                begin
                    bars_reg <= bars_reg + COUNT_W'(1);
                end
            end
            if (cmd.ema_upd)
            begin
                if (cmd.avg_sel)
                begin
                    slow_reg <= up_reg ? slow_reg + step_reg : slow_reg - step_reg;
                end
                else
                begin
                    fast_reg <= up_reg ? fast_reg + step_reg : fast_reg - step_reg;
                end
            end
            if (cmd.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            c_reg   <= PRICE_BITS'(close_price);
            h_reg   <= PRICE_BITS'(high_price);
            l_reg   <= PRICE_BITS'(low_price);
            vol_reg <= VOL_W'(bar_volume);
        end
        if (cmd.prep)
        begin
            d_reg   <= d_w;
            neg_reg <= num_w[NUM_W-1] ^ den_w[DV_W-1];
            rem_reg <= n_w;
            if (zero_w)
            begin
                q_reg       <= '0;
                div_act_reg <= 1'b0;
            end
            else if (n_w >= d_w)
            begin
                q_reg       <= Q_ONE;
                div_act_reg <= 1'b0;
            end
            else
            begin
                q_reg       <= '0;
                div_act_reg <= 1'b1;
            end
        end
        if (cmd.div_step && div_act_reg)
        begin
            q_reg   <= {q_reg[Q_W-2:0], ge_w};
            rem_reg <= ge_w ? rem2_w - d_reg : rem2_w;
        end
        if (cmd.ema_diff)
        begin
            up_reg  <= up_w;
            mag_reg <= up_w ? AVG_W'(x_cur - avg_cur) : AVG_W'(avg_cur - x_cur);
        end
        if (cmd.hi_capture)
        begin
            hi_reg <= mul_reg[GPROD_W-1:0];
        end
        if (cmd.step_calc)
        begin
            step_reg <= AVG_W'({hi_reg, {GAIN_BITS{1'b0}}})
                      + AVG_W'(mul_reg[GPROD_W-1:GAIN_BITS]);
        end
        if (cmd.osc_diff)
        begin
            diff_reg <= DIFF_W'(fast_reg) - DIFF_W'(slow_reg);
        end
        if (cmd.osc_mag)
        begin
            oneg_reg <= diff_reg[DIFF_W-1];
            omag_reg <= dmag_w[DIFF_W-1:GAIN_BITS];
        end
        if (cmd.out_load)
        begin
            osc_reg  <= osc_next;
            vres_reg <= bars_reg >= cfg.warmup_count;
        end
    end

endmodule
